// ----- sv/ffha_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the first-fit heap allocator
// no dependencies

package ffha_pkg;

   localparam int SIZE_W   = 22;
   localparam int ADDR_W   = 22;
   localparam int START_W  = 22;
   localparam int LIMIT_W  = 23;
   localparam int USED_W   = 22;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;

   // internal byte-address width, wide enough for a walk address plus a header
   localparam int WALK_W = 24;

   // table entry: in-use mark above the stored size
   localparam int ENTRY_W = SIZE_W + 1;

   localparam int GAP_BYTES = 4;

   localparam logic [START_W-1:0] HEAP_START_RESET = 22'd1048576;
   localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RESET = 23'd4063232;
   localparam logic [USED_W-1:0]  USED_MAX         = '1;

   localparam logic [CSR_IDX_W-1:0] REG_HEAP_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEAP_LIMIT = 2'd1;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_ZERO_SIZE  = 3'd1,
      STATUS_NO_MEMORY  = 3'd2,
      STATUS_TABLE_FULL = 3'd3,
      STATUS_NOT_FOUND  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_END,
      ST_OUT
   } fsm_state_type;

endpackage

// ----- sv/first_fit_heap_allocator_core.sv -----
`timescale 1ns / 1ps
// first-fit heap allocator: block table in ram, walked one entry per cycle
// depends on ffha_pkg and ffha_ram
//
//   channel | ports                                        | dir
//   --------+----------------------------------------------+-----
//   req     | req_valid req_stall req_mode req_request_size | in
//           | req_release_address                          |
//   rsp     | rsp_valid rsp_stall rsp_payload_address       | out
//           | rsp_status rsp_used_bytes                    |
//   csr     | csr_we csr_index csr_wdata                   | in
//
// one word in flight; a zero-size allocate skips the walk and goes straight to the output state
// a table walk reads one entry a cycle through the single ram read port:
//   a hit goes straight to the output state, a miss passes through the end state first
// reset is synchronous; the table ram needs no clearing pass, entries past
//   the block count are never used before being written
// a result waiting on rsp_stall holds the block in its output state only
//   until the output register frees up

module first_fit_heap_allocator_core #(
   parameter int MAX_BLOCKS   = 256,
   parameter int HEADER_BYTES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [ffha_pkg::SIZE_W-1:0]     req_request_size,
   input  logic [ffha_pkg::ADDR_W-1:0]     req_release_address,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ffha_pkg::ADDR_W-1:0]     rsp_payload_address,
   output logic [ffha_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ffha_pkg::USED_W-1:0]     rsp_used_bytes,
   input  logic                            csr_we,
   input  logic [ffha_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffha_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import ffha_pkg::*;

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0]     COUNT_MAX = CW'(MAX_BLOCKS);
   localparam logic [WALK_W-1:0] HDR       = WALK_W'(HEADER_BYTES);
   localparam logic [WALK_W-1:0] HDR_GAP   = WALK_W'(HEADER_BYTES + GAP_BYTES);
   localparam logic [WALK_W-1:0] GAP       = WALK_W'(GAP_BYTES);

   // control state
   fsm_state_type        state_ff, state_in;
   logic [START_W-1:0]   heap_start_ff, heap_start_in;
   logic [LIMIT_W-1:0]   heap_limit_ff, heap_limit_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [LIMIT_W-1:0]   next_free_ff, next_free_in;
   logic [USED_W-1:0]    bytes_ff, bytes_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // per-word working registers
   logic                 mode_ff, mode_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic [ADDR_W-1:0]    target_ff, target_in;
   logic [WALK_W-1:0]    addr_ff, addr_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [ADDR_W-1:0]    res_payload_ff, res_payload_in;
   status_type           res_status_ff, res_status_in;
   logic [ADDR_W-1:0]    rsp_payload_ff, rsp_payload_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [USED_W-1:0]    rsp_used_ff, rsp_used_in;

   // table ram
   logic                 ram_we;
   logic [IW-1:0]        ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata;
   logic [IW-1:0]        ram_raddr;
   logic [ENTRY_W-1:0]   ram_rdata;

   logic                 e_busy;
   logic [SIZE_W-1:0]    e_size;
   logic [CW-1:0]        idx_plus;
   logic [WALK_W-1:0]    payload_here;
   logic [WALK_W-1:0]    end_addr;
   logic [LIMIT_W-1:0]   amount;
   logic [WALK_W-1:0]    usage_sum;
   logic [USED_W-1:0]    usage_added;
   logic [USED_W-1:0]    usage_taken;
   logic                 rsp_free;

   ffha_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign e_busy       = ram_rdata[ENTRY_W-1];
   assign e_size       = ram_rdata[SIZE_W-1:0];
   assign idx_plus     = idx_ff + CW'(1);
   assign payload_here = addr_ff + HDR;
   assign end_addr     = {1'b0, next_free_ff} + {2'b0, size_ff} + HDR;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;

   // usage accounting, saturating at both ends
   assign amount      = (mode_ff == MODE_FREE) ? ({1'b0, e_size} + LIMIT_W'(HEADER_BYTES))
                                               : ({1'b0, size_ff} + LIMIT_W'(HEADER_BYTES));
   assign usage_sum   = {2'b0, bytes_ff} + {1'b0, amount};
   assign usage_added = (usage_sum > {2'b0, USED_MAX}) ? USED_MAX : usage_sum[USED_W-1:0];
   assign usage_taken = (amount >= {1'b0, bytes_ff}) ? '0 : (bytes_ff - amount[USED_W-1:0]);

   always_comb begin
      state_in       = state_ff;
      heap_start_in  = heap_start_ff;
      heap_limit_in  = heap_limit_ff;
      count_in       = count_ff;
      next_free_in   = next_free_ff;
      bytes_in       = bytes_ff;
      rsp_valid_in   = rsp_valid_ff;
      mode_in        = mode_ff;
      size_in        = size_ff;
      target_in      = target_ff;
      addr_in        = addr_ff;
      idx_in         = idx_ff;
      res_payload_in = res_payload_ff;
      res_status_in  = res_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_used_in    = rsp_used_ff;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff[IW-1:0];
      ram_wdata      = {1'b1, e_size};
      ram_raddr      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // entry 0 is read ahead while idle
            if (req_valid) begin
               mode_in        = req_mode;
               size_in        = req_request_size;
               target_in      = req_release_address;
               addr_in        = {2'b0, heap_start_ff};
               idx_in         = '0;
               res_payload_in = '0;
               if (req_mode == MODE_ALLOC && req_request_size == '0) begin
                  res_status_in = STATUS_ZERO_SIZE;
                  state_in      = ST_OUT;
               end else if (count_ff == '0) begin
                  state_in = ST_END;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            ram_raddr = idx_plus[IW-1:0];
            if (mode_ff == MODE_ALLOC && !e_busy && e_size >= size_ff) begin
               ram_we         = 1'b1;
               ram_wdata      = {1'b1, e_size};
               bytes_in       = usage_added;
               res_payload_in = payload_here[ADDR_W-1:0];
               res_status_in  = STATUS_OK;
               state_in       = ST_OUT;
            end else if (mode_ff == MODE_FREE && payload_here == {2'b0, target_ff}) begin
               // freeing an idle block still takes its size and header off the used-byte count
               ram_we         = 1'b1;
               ram_wdata      = {1'b0, e_size};
               bytes_in       = usage_taken;
               res_status_in  = STATUS_OK;
               state_in       = ST_OUT;
            end else begin
               addr_in = addr_ff + {2'b0, e_size} + HDR_GAP;
               idx_in  = idx_plus;
               if (idx_plus == count_ff) begin
                  state_in = ST_END;
               end
            end
         end
         ST_END: begin
            state_in = ST_OUT;
            if (mode_ff == MODE_FREE) begin
               res_status_in = STATUS_NOT_FOUND;
            end else if (end_addr >= {1'b0, heap_limit_ff}) begin
               res_status_in = STATUS_NO_MEMORY;
            end else if (count_ff >= COUNT_MAX) begin
               res_status_in = STATUS_TABLE_FULL;
            end else begin
               ram_we         = 1'b1;
               ram_waddr      = count_ff[IW-1:0];
               ram_wdata      = {1'b1, size_ff};
               count_in       = count_ff + CW'(1);
               res_payload_in = ADDR_W'({1'b0, next_free_ff} + HDR);
               next_free_in   = LIMIT_W'(end_addr + GAP);
               bytes_in       = usage_added;
               res_status_in  = STATUS_OK;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = res_payload_ff;
               rsp_status_in  = res_status_ff;
               rsp_used_in    = bytes_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            REG_HEAP_START: begin
               heap_start_in = csr_wdata[START_W-1:0];
               count_in      = '0;
               next_free_in  = {1'b0, csr_wdata[START_W-1:0]};
               bytes_in      = '0;
            end
            REG_HEAP_LIMIT: begin
               heap_limit_in = csr_wdata[LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         heap_start_ff <= HEAP_START_RESET;
         heap_limit_ff <= HEAP_LIMIT_RESET;
         count_ff      <= '0;
         next_free_ff  <= {1'b0, HEAP_START_RESET};
         bytes_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         heap_start_ff <= heap_start_in;
         heap_limit_ff <= heap_limit_in;
         count_ff      <= count_in;
         next_free_ff  <= next_free_in;
         bytes_ff      <= bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      size_ff        <= size_in;
      target_ff      <= target_in;
      addr_ff        <= addr_in;
      idx_ff         <= idx_in;
      res_payload_ff <= res_payload_in;
      res_status_ff  <= res_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_payload_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_used_bytes      = rsp_used_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("block count beyond table depth");

   a_walk_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> idx_ff < count_ff)
      else $error("walk index past the last block");

   a_word_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result word loaded outside the output state");

   a_end_above_start: assert property (@(posedge clock) disable iff (reset)
      next_free_ff >= {1'b0, heap_start_ff})
      else $error("heap end below heap start");
`endif

endmodule

// ----- sv/ffha_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
